// File: sv/gelu_pl_pkg.sv
// ----------------------------------------------------------------------------
// GELU piecewise-linear package
// Fixed-point format, thresholds and the knot table of the 16-segment GELU
// approximation.
// ----------------------------------------------------------------------------
package gelu_pl_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int FRAC_BITS   = 12;
	localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int KNOT_COUNT  = 17;
	localparam int SEG_COUNT   = KNOT_COUNT - 1;
	localparam int SEG_BITS    = $clog2(SEG_COUNT);
	localparam int FOUR_INT    = 4 << FRAC_BITS;
	localparam longint NANO    = 64'sd1000000000;

	typedef logic signed [DATA_WIDTH-1:0] sample_t;
	typedef logic signed [DATA_WIDTH:0]   delta_t;
	typedef logic [FRAC_BITS-1:0]         frac_t;
	typedef logic [SEG_BITS-1:0]          seg_t;

	typedef sample_t knot_tab_t  [KNOT_COUNT];
	typedef delta_t  delta_tab_t [SEG_COUNT];

	localparam sample_t POS_FOUR = DATA_WIDTH'(FOUR_INT);
	localparam sample_t NEG_FOUR = DATA_WIDTH'(-FOUR_INT);

	// GELU at x = -4 + k/2, in units of 1e-9.
	localparam longint KNOT_NANO [KNOT_COUNT] = '{
		-64'sd70246,      -64'sd616198,     -64'sd3637392,    -64'sd15084266,
		-64'sd45402306,   -64'sd100428423,  -64'sd158808009,  -64'sd154285990,
		64'sd0,           64'sd345714010,   64'sd841191991,   64'sd1399571577,
		64'sd1954597694,  64'sd2484915734,  64'sd2996362608,  64'sd3499383802,
		64'sd3999929754
	};

	// Rounds each knot to the nearest fixed-point step, ties away from zero.
	function automatic knot_tab_t build_knots();
		knot_tab_t tab;
		longint    v;
		longint    mag;
		longint    q;
		for (int k = 0; k < KNOT_COUNT; k++) begin
			v = KNOT_NANO[k];
			mag = (v < 0) ? -v : v;
			q = (mag * (64'sd1 <<< FRAC_BITS) + NANO / 2) / NANO;
			tab[k] = DATA_WIDTH'((v < 0) ? -q : q);
		end
		return tab;
	endfunction

	localparam knot_tab_t KNOTS = build_knots();

	function automatic delta_tab_t build_deltas();
		delta_tab_t tab;
		for (int k = 0; k < SEG_COUNT; k++) begin
			tab[k] = (DATA_WIDTH+1)'(KNOTS[k+1]) - (DATA_WIDTH+1)'(KNOTS[k]);
		end
		return tab;
	endfunction

	localparam delta_tab_t DELTAS = build_deltas();

endpackage

// File: sv/gelu_piecewise_linear.sv
// ----------------------------------------------------------------------------
// GELU piecewise-linear approximation
// Streams signed Q4.12 samples and returns their GELU approximation over
// 16 linear segments between -4 and +4.
// ----------------------------------------------------------------------------
//  channel  | dir | fields (tdata, lowest bit up)
//  s_axis   | in  | sample_in [15:0]
//  m_axis   | out | gelu_out  [15:0]
//
// Each sample passes from the input transfer through an input register and
// a result register, with the table lookup and one multiply between them.
// One sample is accepted every cycle while the output drains.
// A stall on m_axis holds both registers; s_axis_tready falls only when
// both are full. Reset clears the valid flags.
// ----------------------------------------------------------------------------
module gelu_piecewise_linear (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [gelu_pl_pkg::TDATA_WIDTH-1:0] s_axis_tdata,  // sample_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [gelu_pl_pkg::TDATA_WIDTH-1:0] m_axis_tdata   // gelu_out
);
	import gelu_pl_pkg::*;

	logic    valid_s1;
	logic    valid_s2;
	sample_t sample_s1;
	sample_t result_s2;
	sample_t result;
	logic    adv_s1;
	logic    adv_s2;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata[DATA_WIDTH-1:0];
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	gelu_pl_interp u_interp (
		.sample (sample_s1),
		.result (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_WIDTH'($unsigned(result_s2));

	a_low_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && sample_s1 <= NEG_FOUR) |=> (result_s2 == '0))
		else $error("sample at or below minus four did not give zero");

	a_high_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && sample_s1 >= POS_FOUR) |=> (result_s2 == $past(sample_s1)))
		else $error("sample at or above four did not pass through");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(sample_s1)))
		else $error("input register changed while the result register was stalled");

	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && !valid_s1) |=> !m_axis_tvalid)
		else $error("result shown without a sample behind it");

endmodule

// File: sv/gelu_pl_interp.sv
// ----------------------------------------------------------------------------
// GELU segment interpolator
// Gives zero at or below minus four, passes the sample through at or above
// four, and otherwise interpolates linearly between two knots of the table.
// ----------------------------------------------------------------------------
module gelu_pl_interp (
	input  gelu_pl_pkg::sample_t sample,
	output gelu_pl_pkg::sample_t result
);
	import gelu_pl_pkg::*;

	localparam int PROD_WIDTH = DATA_WIDTH + FRAC_BITS + 2;

	logic signed [DATA_WIDTH:0]   offset;
	seg_t                         seg;
	frac_t                        frac;
	sample_t                      y0;
	delta_t                       delta;
	logic signed [FRAC_BITS:0]    frac_s;
	logic signed [PROD_WIDTH-1:0] prod;
	logic signed [PROD_WIDTH-1:0] prod_sh;
	logic signed [DATA_WIDTH:0]   interp;

	// The offset from minus four, doubled, gives the segment in its integer
	// bits and the fraction in its low bits.
	assign offset  = (DATA_WIDTH+1)'(sample) + (DATA_WIDTH+1)'(FOUR_INT);
	assign seg     = offset[FRAC_BITS+2:FRAC_BITS-1];
	assign frac    = {offset[FRAC_BITS-2:0], 1'b0};
	assign y0      = KNOTS[{1'b0, seg}];
	assign delta   = DELTAS[seg];
	assign frac_s  = $signed({1'b0, frac});
	assign prod    = PROD_WIDTH'(delta) * PROD_WIDTH'(frac_s);
	assign prod_sh = prod >>> FRAC_BITS;
	assign interp  = (DATA_WIDTH+1)'(y0) + prod_sh[DATA_WIDTH:0];

	always_comb begin
		if (sample <= NEG_FOUR) begin
			result = '0;
		end else if (sample >= POS_FOUR) begin
			result = sample;
		end else begin
			result = interp[DATA_WIDTH-1:0];
		end
	end

endmodule
